FILE: hdl/gwm_pkg.sv
// shared types and constants for the wildcard glob matcher
package gwm_pkg;

  localparam int DEFAULT_MAX_PATTERN = 64;
  localparam int CHAR_W = 8;
  localparam int POS_W = 6;
  localparam int KIND_W = 2;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_CHAR = 8'h3F;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END = 2'd2;

  localparam logic [PADDR_W-1:0] ADDR_PATTERN_LENGTH = 2'd0;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic              load;
    logic [POS_W-1:0]  load_pos;
    logic [CHAR_W-1:0] load_char;
    logic              hop;
    logic              step;
    logic              rearm;
    logic [CHAR_W-1:0] text;
  } cell_ctl_t;

endpackage

FILE: hdl/gwm_cell.sv
// one pattern position: stored pattern byte and its active bit
module gwm_cell import gwm_pkg::*; #(
  parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN,
  parameter int INDEX = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cell_ctl_t                            ctl,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]     length,
  input  logic                                 hop_in,
  input  logic                                 fwd_in,
  output logic                                 hop_out,
  output logic                                 fwd_out,
  output logic                                 grow,
  output logic                                 active
);

  localparam int IDX_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;

  logic [CHAR_W-1:0] pattern_char;
  logic              en;
  logic              is_star;
  logic              hit;

  assign en      = IDX_W'(INDEX) < length;
  assign is_star = pattern_char == STAR_CHAR;
  assign hit     = (pattern_char == ANY_CHAR) || (pattern_char == ctl.text);
  assign hop_out = active && en && is_star;
  assign fwd_out = active && en && !is_star && hit;
  assign grow    = hop_in && !active;

  always_ff @(posedge clk) begin
    if (ctl.load && (CMP_W'(ctl.load_pos) == CMP_W'(INDEX))) begin
      pattern_char <= ctl.load_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.rearm) begin
      active <= (INDEX == 0);
    end else if (ctl.hop) begin
      active <= active || hop_in;
    end else if (ctl.step) begin
      // a star keeps its own bit, a matching byte moves its bit right
      active <= (active && en && is_star) || fwd_in;
    end
  end

endmodule

FILE: hdl/gwm_ctrl.sv
// handshake, closure sequencing and result register
module gwm_ctrl import gwm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [POS_W-1:0]  position,
  input  logic [CHAR_W-1:0] char_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              matched,
  input  logic              cfg_rearm,
  input  logic              any_grow,
  input  logic              goal,
  output cell_ctl_t         ctl
);

  typedef enum logic {IDLE, CLOSE} state_t;

  state_t            state;
  logic              hold_end;
  logic [CHAR_W-1:0] hold_char;
  logic              accept;
  logic              slot_free;
  logic              finish_end;

  assign in_stall   = (state == CLOSE);
  assign accept     = in_valid && !in_stall;
  assign slot_free  = !out_valid || !out_stall;
  assign finish_end = (state == CLOSE) && !any_grow && hold_end && slot_free;

  always_comb begin
    ctl.load      = accept && (kind == KIND_LOAD);
    ctl.load_pos  = position;
    ctl.load_char = char_value;
    ctl.hop       = (state == CLOSE) && any_grow;
    ctl.step      = (state == CLOSE) && !any_grow && !hold_end;
    ctl.rearm     = cfg_rearm || finish_end;
    ctl.text      = hold_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result may replace one taken in the same cycle
      if (finish_end) begin
        out_valid <= 1'b1;
        matched   <= goal;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept && (kind inside {KIND_TEXT, KIND_END})) begin
            hold_end  <= (kind == KIND_END);
            hold_char <= char_value;
            state     <= CLOSE;
          end
        end
        CLOSE: begin
          if (ctl.step || finish_end) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_ctl_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.hop, ctl.step, finish_end}))
    else $error("conflicting cell commands");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == CLOSE && hold_end && !any_grow))
    else $error("result word without finished end of text");

  a_step_returns: assert property (@(posedge clk) disable iff (rst)
    (ctl.step || finish_end) |=> (state == IDLE))
    else $error("sequencer did not return to idle");

endmodule

FILE: hdl/wildcard_glob_matcher.sv
// wildcard glob matcher top level: register port, control and cell chain
//
// Matches a text against a wildcard pattern where '*' matches any run of bytes
// (including none), '?' matches exactly one byte and any other byte matches
// itself. Pattern bytes are loaded with kind 0 words (position selects the
// slot, loads at or beyond MAX_PATTERN land nowhere), the pattern length is set
// through the register at address 0 (values above MAX_PATTERN saturate, and a
// write rearms the match), text bytes come as kind 1 words, and a kind 2 word
// ends the text, returns one result word with matched set when the whole text
// matched, and rearms for the next text. An empty pattern matches only empty
// text; kind 3 words are dropped. Load and dropped words do not enter closure.
// A text byte first runs closure passes over '*' positions and then advances
// the row; end of text runs the same closure and then waits for a free result
// slot. The active bits cross one '*' cell per cycle, so the closure runs longer
// the longer the run of consecutive '*' that the active row reaches
// (no extra passes for patterns without '*'). The input stalls during that closure;
// a finished result sits in its own register and does not block new words.
module wildcard_glob_matcher import gwm_pkg::*; #(
  parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN
) (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KIND_W-1:0]  kind,
  input  logic [POS_W-1:0]   position,
  input  logic [CHAR_W-1:0]  char_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               matched,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0]     length;
  logic                 cfg_wr;
  cell_ctl_t            ctl;
  // row of active bits; the last entry is a goal-only position
  logic [MAX_PATTERN:0] row;
  logic [MAX_PATTERN:0] hop_w;
  logic [MAX_PATTERN:0] fwd_w;
  logic [MAX_PATTERN:0] grow_w;
  logic                 any_grow;
  logic                 goal;

  // register port: single register, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_PATTERN_LENGTH);
  assign prdata = (paddr == ADDR_PATTERN_LENGTH) ? PDATA_W'(length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (cfg_wr) begin
      // saturate at store depth
      if (pwdata > PDATA_W'(MAX_PATTERN)) begin
        length <= LEN_W'(MAX_PATTERN);
      end else begin
        length <= pwdata[LEN_W-1:0];
      end
    end
  end

  gwm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .position   (position),
    .char_value (char_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .matched    (matched),
    .cfg_rearm  (cfg_wr),
    .any_grow   (any_grow),
    .goal       (goal),
    .ctl        (ctl)
  );

  // chain of cells: each hands its closure and advance bits to the right
  for (genvar j = 0; j <= MAX_PATTERN; j++) begin : g_cell
    logic hop_in;
    logic fwd_in;
    if (j == 0) begin : g_head
      assign hop_in = 1'b0;
      assign fwd_in = 1'b0;
    end else begin : g_link
      assign hop_in = hop_w[j-1];
      assign fwd_in = fwd_w[j-1];
    end
    gwm_cell #(
      .MAX_PATTERN (MAX_PATTERN),
      .INDEX       (j)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .length  (length),
      .hop_in  (hop_in),
      .fwd_in  (fwd_in),
      .hop_out (hop_w[j]),
      .fwd_out (fwd_w[j]),
      .grow    (grow_w[j]),
      .active  (row[j])
    );
  end

  // closure is done once no cell would gain a bit
  assign any_grow = |grow_w;
  // goal bit sits at the position just past the pattern
  assign goal = row[length];

  a_rearm_row: assert property (@(posedge clk) disable iff (rst)
    ctl.rearm |=> (row == (MAX_PATTERN + 1)'(1)))
    else $error("active row not rearmed");

endmodule

FILE: bench/glob_match_checker.sv
// checker for the wildcard glob matcher: tracks the active row and compares verdict words
module glob_match_checker import gwm_pkg::*; #(
  parameter int MAXP = DEFAULT_MAX_PATTERN
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [KIND_W-1:0]  kind,
  input  logic [POS_W-1:0]   position,
  input  logic [CHAR_W-1:0]  char_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               matched,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 pending,
  output int                 mismatches,
  output int                 results,
  output int                 hits
);

  logic [CHAR_W-1:0] pat_mem [MAXP];
  logic [MAXP:0]     live;
  int                plen;
  logic              verdicts [$];

  // carry active bits across '*' cells, lowest position first
  function automatic logic [MAXP:0] star_closure(input logic [MAXP:0] row);
    logic [MAXP:0] r;
    r = row;
    for (int j = 0; j < MAXP; j++) begin
      if (j < plen && r[j] && pat_mem[j] == STAR_CHAR) r[j+1] = 1'b1;
    end
    return r;
  endfunction

  // consume one text byte
  function automatic logic [MAXP:0] byte_step(input logic [MAXP:0] row,
                                              input logic [CHAR_W-1:0] ch);
    logic [MAXP:0] nxt;
    nxt = '0;
    for (int j = 0; j < MAXP; j++) begin
      if (j < plen && row[j]) begin
        if (pat_mem[j] == STAR_CHAR) nxt[j] = 1'b1;
        else if (pat_mem[j] == ANY_CHAR || pat_mem[j] == ch) nxt[j+1] = 1'b1;
      end
    end
    return nxt;
  endfunction

  initial begin
    foreach (pat_mem[i]) pat_mem[i] = '0;
    live = 1;
    plen = 0;
    pending = 0;
    mismatches = 0;
    results = 0;
    hits = 0;
  end

  always @(posedge clk) begin : watch
    logic [MAXP:0] row;
    logic          want;
    if (rst) begin
      plen = 0;
      live = 1;
      verdicts.delete();
    end else begin
      // length write saturates and rearms
      if (psel && penable && pwrite && pready && paddr == ADDR_PATTERN_LENGTH) begin
        plen = (pwdata > MAXP) ? MAXP : int'(pwdata);
        live = 1;
      end
      if (in_valid && !in_stall) begin
        case (kind)
          KIND_LOAD: if (position < MAXP) pat_mem[position] = char_value;
          KIND_TEXT: live = byte_step(star_closure(live), char_value);
          KIND_END: begin
            row = star_closure(live);
            verdicts.push_back(row[plen]);
            live = 1;
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results++;
        if (matched) hits++;
        if (verdicts.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, got matched=%0b",
                   $time, matched);
        end else begin
          want = verdicts.pop_front();
          if (matched !== want) begin
            mismatches++;
            $display("%0t: matched mismatch, expected %0b, got %0b", $time, want, matched);
          end
        end
      end
    end
    pending = verdicts.size();
  end

endmodule

FILE: bench/tb_wildcard_glob_matcher.sv
// testbench top for the wildcard glob matcher: stimulus, backpressure and verdict
module tb_wildcard_glob_matcher;
  import gwm_pkg::*;

  localparam int MAX_LEN = DEFAULT_MAX_PATTERN;
  localparam int ITEM_TARGET = 850;
  // drain time after the last verdict, covering any word still in closure
  localparam int DRAIN_CYCLES = 80;
  // watchdog limit, well above the longest legal quiet stretch (closure plus stall plus gap)
  localparam int QUIET_LIMIT = 2000;
  // the unused kind code, dropped by the block
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [KIND_W-1:0]  kind = KIND_LOAD;
  logic [POS_W-1:0]   position = '0;
  logic [CHAR_W-1:0]  char_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               matched;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = ADDR_PATTERN_LENGTH;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int pending;
  int mismatches;
  int results;
  int hits;

  // stimulus bookkeeping
  logic [CHAR_W-1:0] pat_copy [MAX_LEN];
  logic [CHAR_W-1:0] text_buf [$];
  int                cur_len = 0;
  int                burst_left = 0;
  int                words_sent = 0;
  int                settings = 0;
  int                quiet = 0;

  // receiver backpressure state
  int stall_mode = 0;
  int mode_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  wildcard_glob_matcher i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .position   (position),
    .char_value (char_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .matched    (matched),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  glob_match_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .position   (position),
    .char_value (char_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .matched    (matched),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .pending    (pending),
    .mismatches (mismatches),
    .results    (results),
    .hits       (hits)
  );

  // receiver: switches between no stall, light random stall and heavy stall
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 150);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // watchdog: any accepted word, taken result word, register access or reset counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("wildcard_glob_matcher verification failed");
    $finish;
  end

  // often a small alphabet so that literals meet, with wildcards and full-range bytes
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'h61 + CHAR_W'($urandom_range(0, 2));
    else if (r == 4) return STAR_CHAR;
    else if (r == 5) return ANY_CHAR;
    else return CHAR_W'($urandom_range(0, 255));
  endfunction

  // one word on the item channel; the sender runs in bursts with gaps between them.
  // called and returning at a falling edge; valid stays up across a burst
  task automatic send_word(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                           input logic [CHAR_W-1:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      // an occasional long burst gives stretches with no sender idling
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    kind <= k;
    position <= p;
    char_value <= c;
    do begin
      @(posedge clk);
    end while (in_stall);
    burst_left--;
    if (k != KIND_SPARE) words_sent++;
    @(negedge clk);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic write_length(input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_PATTERN_LENGTH;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_len = (value > MAX_LEN) ? MAX_LEN : int'(value);
    settings++;
  endtask

  // drop valid, let every verdict come out, then give closure time to finish
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_pattern();
    for (int j = 0; j < cur_len; j++) send_word(KIND_LOAD, POS_W'(j), pat_copy[j]);
  endtask

  // text bytes from text_buf, then end of text; the noisy form mixes in
  // pattern rewrites mid-text and dropped words
  task automatic send_text(input bit noisy);
    int p;
    logic [CHAR_W-1:0] c;
    foreach (text_buf[i]) begin
      if (noisy && $urandom_range(0, 11) == 0) begin
        p = $urandom_range(0, MAX_LEN - 1);
        c = pick_char();
        pat_copy[p] = c;
        send_word(KIND_LOAD, POS_W'(p), c);
      end
      if (noisy && $urandom_range(0, 19) == 0)
        send_word(KIND_SPARE, POS_W'($urandom_range(0, 63)), CHAR_W'($urandom_range(0, 255)));
      send_word(KIND_TEXT, POS_W'($urandom_range(0, 63)), text_buf[i]);
    end
    send_word(KIND_END, POS_W'($urandom_range(0, 63)), CHAR_W'($urandom_range(0, 255)));
  endtask

  // a text either built to fit the pattern (then sometimes damaged) or plain noise
  task automatic make_text(input bit derived);
    int n;
    logic [CHAR_W-1:0] c;
    text_buf.delete();
    if (!derived) begin
      n = $urandom_range(0, 8);
      repeat (n) text_buf.push_back(pick_char());
    end else begin
      for (int j = 0; j < cur_len; j++) begin
        c = pat_copy[j];
        if (c == STAR_CHAR) begin
          n = $urandom_range(0, (cur_len > 16) ? 1 : 3);
          repeat (n) text_buf.push_back(pick_char());
        end else if (c == ANY_CHAR) begin
          text_buf.push_back(pick_char());
        end else begin
          text_buf.push_back(c);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: if (text_buf.size() > 0)
               text_buf[$urandom_range(0, text_buf.size() - 1)] = pick_char();
          1: if (text_buf.size() > 0)
               text_buf.delete($urandom_range(0, text_buf.size() - 1));
          default: text_buf.insert($urandom_range(0, text_buf.size()), pick_char());
        endcase
      end
    end
  endtask

  initial begin : stimulus
    int dir_words;
    int pick;
    int n_texts;
    logic [PDATA_W-1:0] len_word;
    bit all_stars;

    foreach (pat_copy[i]) pat_copy[i] = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty pattern from reset: empty text matches, one byte does not
    text_buf = {};
    send_text(1'b0);
    text_buf = {8'h61};
    send_text(1'b0);
    // dropped word
    send_word(KIND_SPARE, 6'h3F, 8'hFF);

    // extreme bytes with both wildcards
    settle();
    write_length(32'd4);
    pat_copy[0] = 8'h00;
    pat_copy[1] = ANY_CHAR;
    pat_copy[2] = STAR_CHAR;
    pat_copy[3] = 8'hFF;
    load_pattern();
    text_buf = {8'h00, 8'h41, 8'hFF};
    send_text(1'b0);
    text_buf = {8'h00, 8'h41, 8'h42, 8'h2A, 8'hFF};
    send_text(1'b0);
    // '?' needs exactly one byte
    text_buf = {8'h00, 8'hFF};
    send_text(1'b0);
    text_buf = {8'h00, 8'h41};
    send_text(1'b0);

    // rewriting the last pattern byte in the middle of a text keeps the row
    send_word(KIND_TEXT, 6'd0, 8'h00);
    pat_copy[3] = 8'h5A;
    send_word(KIND_LOAD, 6'd3, 8'h5A);
    send_word(KIND_TEXT, 6'd0, 8'h41);
    send_word(KIND_TEXT, 6'd0, 8'h5A);
    send_word(KIND_END, 6'd0, 8'h00);

    // a length write in the middle of a text rearms the row
    send_word(KIND_TEXT, 6'd0, 8'h00);
    settle();
    write_length(32'd0);
    send_word(KIND_END, 6'd63, 8'hFF);
    dir_words = words_sent;

    // random phases: new length, fresh pattern, then a few texts
    while (words_sent < dir_words + ITEM_TARGET) begin
      settle();
      pick = $urandom_range(0, 31);
      case (pick)
        0: len_word = 32'd0;
        1: len_word = 32'd64;
        2: len_word = PDATA_W'($urandom_range(65, 127));
        3: len_word = $urandom() | 32'h8000_0000;
        4: len_word = PDATA_W'($urandom_range(11, 40));
        default: len_word = PDATA_W'($urandom_range(1, 10));
      endcase
      write_length(len_word);
      // long patterns are sometimes all '*' to drive the deepest closure
      all_stars = (cur_len >= 32) && ($urandom_range(0, 1) == 1);
      for (int j = 0; j < cur_len; j++) pat_copy[j] = all_stars ? STAR_CHAR : pick_char();
      load_pattern();
      n_texts = (cur_len > 16) ? 2 : $urandom_range(3, 8);
      repeat (n_texts) begin
        make_text($urandom_range(0, 9) < 7);
        send_text(1'b1);
      end
    end

    if (in_valid) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d input words over %0d length settings", words_sent, settings);
    $display("%0d verdict words seen, %0d of them matches, %0d mismatches",
             results, hits, mismatches);
    if (mismatches == 0)
      $display("wildcard_glob_matcher verification clean");
    else
      $display("wildcard_glob_matcher verification failed");
    $finish;
  end

endmodule

FILE: files.f
hdl/gwm_pkg.sv
hdl/gwm_cell.sv
hdl/gwm_ctrl.sv
hdl/wildcard_glob_matcher.sv
bench/glob_match_checker.sv
bench/tb_wildcard_glob_matcher.sv
